// ===== design/mtnp_pkg.sv =====
package mtnp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    EV_NOTE_START = 3'd0,
    EV_NOTE_END   = 3'd1,
    EV_TEMPO      = 3'd2,
    EV_LOOP_BACK  = 3'd3,
    EV_FINISHED   = 3'd4,
    EV_ERROR      = 3'd5
  } event_kind_t;

  // Byte parser phases
  typedef enum logic [9:0] {
    PH_DELTA      = 10'b00_0000_0001,
    PH_STATUS     = 10'b00_0000_0010,
    PH_DATA1      = 10'b00_0000_0100,
    PH_DATA2      = 10'b00_0000_1000,
    PH_META_TYPE  = 10'b00_0001_0000,
    PH_META_LEN   = 10'b00_0010_0000,
    PH_META_BODY  = 10'b00_0100_0000,
    PH_SYSEX_ID   = 10'b00_1000_0000,
    PH_SYSEX_SKIP = 10'b01_0000_0000,
    PH_HALT       = 10'b10_0000_0000
  } phase_t;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] SYSEX_AME    = 8'h75;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] PROG_NONE    = 8'hFF;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY      = 4'hA;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;
  localparam logic [3:0] PASSES_RESET = 4'd2;
  localparam int         EPOCH_W      = 4;

  typedef struct packed {
    event_kind_t  kind;
    logic [31:0]  tick;
    logic [3:0]   channel;
    logic [7:0]   note;
    logic [7:0]   program_res;
    logic [15:0]  note_number;
    logic [23:0]  tempo;
  } result_t;

endpackage

// ===== design/mtnp_ifs.sv =====
interface mtnp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, data_byte, track_start, input ready);
  modport sink (input valid, data_byte, track_start, output ready);
endinterface

interface mtnp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] tick;
  logic [3:0]  channel;
  logic [7:0]  note;
  logic [7:0]  program_res;
  logic [15:0] note_number;
  logic [23:0] tempo;

  modport source (output valid, event_kind, tick, channel, note, program_res, note_number,
                  tempo, input ready);
  modport sink (input valid, event_kind, tick, channel, note, program_res, note_number,
                tempo, output ready);
endinterface

// ===== design/mtnp_out_queue.sv =====
module mtnp_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtnp_pkg::result_t item,
  output logic              full,
  mtnp_event_if.source      event_out
);
  import mtnp_pkg::*;

  result_t    q0;
  result_t    q1;
  logic [1:0] count;
  logic       pop;

  assign pop  = event_out.valid && event_out.ready;
  assign full = (count == 2'd2);

  // Advance the two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        q0 <= q1;
        if (push) q1 <= item;
      end else if (push) begin
        q0 <= item;
      end
    end else if (push) begin
      if (count == 2'd0) q0 <= item;
      else q1 <= item;
    end
  end

  // Present the head item
  assign event_out.valid       = (count != 2'd0);
  assign event_out.event_kind  = q0.kind;
  assign event_out.tick        = q0.tick;
  assign event_out.channel     = q0.channel;
  assign event_out.note        = q0.note;
  assign event_out.program_res = q0.program_res;
  assign event_out.note_number = q0.note_number;
  assign event_out.tempo       = q0.tempo;

endmodule

// ===== design/midi_track_note_event_parser.sv =====
// Parses a MIDI track one byte per item and reports note starts, note ends, tempo changes,
// loop-back, finished and errors. The open-note count memory is read at acceptance and
// written back in the following cycle, and the next byte is held off until that write
// lands. After reset, and at every sixteenth track_start, the count memory gets a clearing
// pass over all CHANNELS*128 entries (2048 by default) during which no byte is taken; other
// track starts clear the counts at once through an epoch tag kept with each entry. Results
// wait in a two-entry output queue, so bytes keep flowing while a result waits until it fills.
module midi_track_note_event_parser #(
  parameter int CHANNELS = 16,
  parameter int MAX_OPEN = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  mtnp_byte_if.sink    byte_in,
  mtnp_event_if.source event_out
);
  import mtnp_pkg::*;

  localparam int CW    = $clog2(MAX_OPEN + 1);
  localparam int DEPTH = CHANNELS * 128;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0]         CH_LIM     = 5'(CHANNELS);
  localparam logic [CW-1:0]      OPEN_MAX   = CW'(MAX_OPEN);
  localparam logic [AW-1:0]      LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CW-1:0]      cnt;
  } slot_t;

  typedef enum logic [2:0] {
    SQ_CLEAR = 3'b001,
    SQ_IDLE  = 3'b010,
    SQ_EXEC  = 3'b100
  } seq_t;

  seq_t               sq;
  logic [AW-1:0]      clr_addr;
  logic               hold;
  logic [EPOCH_W-1:0] epoch;
  logic [7:0]         s_byte;
  logic               s_ts;
  logic [AW-1:0]      s_addr;
  slot_t              mem [DEPTH];
  slot_t              mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  slot_t              mem_wd;
  logic               q_full;
  logic               accept;
  logic               exec;
  logic [7:0]         key_sel;
  logic [10:0]        addr_full;
  logic [AW-1:0]      rd_addr;

  // Parse state
  logic [3:0]  track_passes;
  phase_t      phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [31:0] tick_count, tick_count_next;
  logic [27:0] delta_acc, delta_acc_next;
  logic [7:0]  first_data, first_data_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [7:0]  meta_rem, meta_rem_next;
  logic [23:0] tempo_asm, tempo_asm_next;
  logic [1:0]  tempo_got, tempo_got_next;
  logic [15:0] note_seq, note_seq_next;
  logic [3:0]  passes_left, passes_left_next;
  logic [7:0]  prog_tab [CHANNELS];

  logic          prog_clear;
  logic          prog_we;
  logic          emit;
  result_t       res;
  logic          cnt_we;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] cnt_v;
  logic [3:0]    ch;
  logic [3:0]    hi;
  logic          ch_ok;

  assign accept = byte_in.valid && byte_in.ready;
  assign exec   = (sq == SQ_EXEC);
  assign byte_in.ready = (sq == SQ_IDLE) && !q_full;

  // Count memory address from the incoming byte and the settled state
  assign key_sel   = (phase == PH_DATA2) ? first_data : byte_in.data_byte;
  assign addr_full = {running_status[3:0], key_sel[6:0]};
  assign rd_addr   = addr_full[AW-1:0];

  // Sequence clearing, acceptance and execution
  always_ff @(posedge clk) begin
    if (rst) begin
      sq       <= SQ_CLEAR;
      clr_addr <= '0;
      hold     <= 1'b0;
      epoch    <= '0;
    end else begin
      unique case (sq)
        SQ_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            hold     <= 1'b0;
            sq       <= hold ? SQ_EXEC : SQ_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        SQ_IDLE: begin
          if (accept) begin
            if (byte_in.track_start && epoch == EPOCH_LAST) begin
              hold <= 1'b1;
              sq   <= SQ_CLEAR;
            end else begin
              sq <= SQ_EXEC;
            end
          end
        end
        SQ_EXEC: begin
          sq <= SQ_IDLE;
          if (s_ts) epoch <= epoch + 1'b1;
        end
        default: sq <= SQ_CLEAR;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      s_byte <= byte_in.data_byte;
      s_ts   <= byte_in.track_start;
      s_addr <= rd_addr;
    end
  end

  // Count memory: read at acceptance, write back or clear
  assign mem_we = (sq == SQ_CLEAR) || (exec && cnt_we);
  assign mem_wa = (sq == SQ_CLEAR) ? clr_addr : s_addr;
  assign mem_wd = (sq == SQ_CLEAR) ? slot_t'('0) : slot_t'({epoch, cnt_new});

  always_ff @(posedge clk) begin
    if (accept) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  assign cnt_v = (mem_q.tag == epoch) ? mem_q.cnt : '0;

  // Parse one byte
  always_comb begin
    logic          err;
    logic          d1;
    logic          do_end;
    logic [7:0]    end_key;
    logic [7:0]    b;
    logic [3:0]    passes_dec;
    phase_t        ph;

    b                   = s_byte;
    err                 = 1'b0;
    d1                  = 1'b0;
    do_end              = 1'b0;
    end_key             = b;
    passes_dec          = 4'd0;
    phase_next          = phase;
    running_status_next = running_status;
    tick_count_next     = tick_count;
    delta_acc_next      = delta_acc;
    first_data_next     = first_data;
    meta_type_next      = meta_type;
    meta_rem_next       = meta_rem;
    tempo_asm_next      = tempo_asm;
    tempo_got_next      = tempo_got;
    note_seq_next       = note_seq;
    passes_left_next    = passes_left;
    prog_clear          = 1'b0;
    prog_we             = 1'b0;
    emit                = 1'b0;
    res                 = '0;
    cnt_we              = 1'b0;
    cnt_new             = cnt_v;

    // Track start resets the parse state and reloads the pass count before the byte is parsed
    if (s_ts) begin
      phase_next          = PH_DELTA;
      running_status_next = 8'd0;
      tick_count_next     = 32'd0;
      delta_acc_next      = 28'd0;
      first_data_next     = 8'd0;
      meta_type_next      = 8'd0;
      meta_rem_next       = 8'd0;
      tempo_asm_next      = 24'd0;
      tempo_got_next      = 2'd0;
      note_seq_next       = 16'd0;
      passes_left_next    = track_passes;
      prog_clear          = 1'b1;
    end

    ph    = phase_next;
    ch    = running_status_next[3:0];
    hi    = running_status_next[7:4];
    ch_ok = ({1'b0, ch} < CH_LIM);

    unique case (ph)
      PH_DELTA: begin
        delta_acc_next = {delta_acc_next[20:0], b[6:0]};
        if (!b[7]) begin
          tick_count_next = tick_count_next + {4'd0, delta_acc_next};
          delta_acc_next  = 28'd0;
          phase_next      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (b == ST_META) begin
            running_status_next = 8'd0;
            phase_next          = PH_META_TYPE;
          end else if (b == ST_SYSEX) begin
            running_status_next = 8'd0;
            phase_next          = PH_SYSEX_ID;
          end else if (b[7:4] == HI_POLY || b[7:4] == HI_SYSTEM) begin
            err = 1'b1;
          end else begin
            running_status_next = b;
            phase_next          = PH_DATA1;
          end
        end else if (running_status_next == 8'd0) begin
          err = 1'b1;
        end else begin
          d1 = 1'b1;
        end
      end
      PH_DATA1: d1 = 1'b1;
      PH_DATA2: begin
        phase_next = PH_DELTA;
        if (hi == HI_NOTE_ON && b != 8'd0) begin
          emit            = 1'b1;
          res.kind        = EV_NOTE_START;
          res.channel     = ch;
          res.note        = first_data_next;
          res.program_res = ch_ok ? prog_tab[ch[PW-1:0]] : PROG_NONE;
          res.note_number = note_seq_next;
          note_seq_next   = note_seq_next + 16'd1;
          if (ch_ok && cnt_v < OPEN_MAX) begin
            cnt_we  = 1'b1;
            cnt_new = cnt_v + 1'b1;
          end
        end else if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
          do_end  = 1'b1;
          end_key = first_data_next;
        end
      end
      PH_META_TYPE: begin
        meta_type_next = b;
        phase_next     = PH_META_LEN;
      end
      PH_META_LEN: begin
        if (meta_type_next == META_EOT) begin
          passes_dec       = (passes_left_next != 4'd0) ? passes_left_next - 4'd1 : 4'd0;
          passes_left_next = passes_dec;
          emit             = 1'b1;
          if (passes_dec == 4'd0) begin
            phase_next = PH_HALT;
            res.kind   = EV_FINISHED;
          end else begin
            phase_next = PH_DELTA;
            res.kind   = EV_LOOP_BACK;
          end
        end else begin
          meta_rem_next  = b;
          tempo_asm_next = 24'd0;
          tempo_got_next = 2'd0;
          phase_next     = (b == 8'd0) ? PH_DELTA : PH_META_BODY;
        end
      end
      PH_META_BODY: begin
        if (meta_type_next == META_TEMPO && tempo_got_next != 2'd3) begin
          tempo_asm_next = {tempo_asm_next[15:0], b};
          tempo_got_next = tempo_got_next + 2'd1;
          if (tempo_got_next == 2'd3) begin
            emit      = 1'b1;
            res.kind  = EV_TEMPO;
            res.tempo = tempo_asm_next;
          end
        end
        meta_rem_next = meta_rem_next - 8'd1;
        if (meta_rem_next == 8'd0) phase_next = PH_DELTA;
      end
      PH_SYSEX_ID: begin
        if (b != SYSEX_AME) err = 1'b1;
        else phase_next = PH_SYSEX_SKIP;
      end
      PH_SYSEX_SKIP: begin
        if (b == SYSEX_END) phase_next = PH_DELTA;
      end
      PH_HALT: phase_next = PH_HALT;
      default: phase_next = PH_HALT;
    endcase

    // First data byte of a channel message
    if (d1) begin
      if (hi == HI_PROGRAM) begin
        prog_we    = ch_ok;
        phase_next = PH_DELTA;
      end else if (hi == HI_PRESSURE) begin
        phase_next = PH_DELTA;
        do_end     = 1'b1;
        end_key    = b;
      end else begin
        first_data_next = b;
        phase_next      = PH_DATA2;
      end
    end

    // End one open note of this channel and key
    if (do_end && ch_ok && cnt_v != '0) begin
      cnt_we      = 1'b1;
      cnt_new     = cnt_v - 1'b1;
      emit        = 1'b1;
      res.kind    = EV_NOTE_END;
      res.channel = ch;
      res.note    = end_key;
    end

    if (err) begin
      phase_next = PH_HALT;
      emit       = 1'b1;
      res        = '0;
      res.kind   = EV_ERROR;
    end

    res.tick = tick_count_next;
  end

  // Hold parse state and the pass register
  always_ff @(posedge clk) begin
    if (rst) begin
      track_passes   <= PASSES_RESET;
      phase          <= PH_DELTA;
      running_status <= 8'd0;
      tick_count     <= 32'd0;
      delta_acc      <= 28'd0;
      first_data     <= 8'd0;
      meta_type      <= 8'd0;
      meta_rem       <= 8'd0;
      tempo_asm      <= 24'd0;
      tempo_got      <= 2'd0;
      note_seq       <= 16'd0;
      passes_left    <= PASSES_RESET;
    end else begin
      if (cfg_we) track_passes <= cfg_wdata;
      if (exec) begin
        phase          <= phase_next;
        running_status <= running_status_next;
        tick_count     <= tick_count_next;
        delta_acc      <= delta_acc_next;
        first_data     <= first_data_next;
        meta_type      <= meta_type_next;
        meta_rem       <= meta_rem_next;
        tempo_asm      <= tempo_asm_next;
        tempo_got      <= tempo_got_next;
        note_seq       <= note_seq_next;
        passes_left    <= passes_left_next;
      end
    end
  end

  // Update the program table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) prog_tab[i] <= PROG_NONE;
    end else if (exec) begin
      if (prog_clear) begin
        for (int i = 0; i < CHANNELS; i++) prog_tab[i] <= PROG_NONE;
      end else if (prog_we) begin
        prog_tab[ch[PW-1:0]] <= s_byte;
      end
    end
  end

  mtnp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (exec && emit),
    .item      (res),
    .full      (q_full),
    .event_out (event_out)
  );

endmodule

// ===== design/mtnp_checker.sv =====
module mtnp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [3:0]  channel,
  input logic [7:0]  note,
  input logic [7:0]  program_res,
  input logic [15:0] note_number,
  input logic [23:0] tempo
);
  import mtnp_pkg::*;

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(tempo))
    else $error("stalled result changed");

  // No byte is accepted while the previous byte's read-modify-write is in progress
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted during read-modify-write");

  // Note fields are zero outside note events
  a_note_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_NOTE_START && event_kind != EV_NOTE_END
      |-> channel == 4'd0 && note == 8'd0)
    else $error("note fields set on non-note result");

  // Program, sequence and tempo belong to their own kinds
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == EV_NOTE_START || (program_res == 8'd0 && note_number == 16'd0))
      && (event_kind == EV_TEMPO || tempo == 24'd0))
    else $error("field set on wrong result kind");

endmodule

bind midi_track_note_event_parser mtnp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (byte_in.valid),
  .in_ready    (byte_in.ready),
  .out_valid   (event_out.valid),
  .out_ready   (event_out.ready),
  .event_kind  (event_out.event_kind),
  .channel     (event_out.channel),
  .note        (event_out.note),
  .program_res (event_out.program_res),
  .note_number (event_out.note_number),
  .tempo       (event_out.tempo)
);
